FILE: sv/assert_macros.svh
// assertion macros used by the ranker top level
// needs a clk and an active-high rst in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define CGPR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cgpr assertion failed");

// condition that must hold in the cycle after a trigger
`define CGPR_ASSERT_NEXT(lbl, trig, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error("cgpr assertion failed");

`endif

FILE: sv/cgpr_pkg.sv
// types, constants and bit helpers of the circular gap pattern ranker
// no dependencies
package cgpr_pkg;

  localparam int MaxBits = 32;
  localparam int MinBits = 8;
  localparam int RegPatternBits = 0;

  typedef struct packed {
    logic [31:0] pattern_a;
    logic [31:0] pattern_b;
  } item_t;

  typedef struct packed {
    logic       a_better;
    logic       a_valid;
    logic       b_valid;
    logic [4:0] a_min_gap;
    logic [4:0] b_min_gap;
  } result_t;

  typedef logic [31:0][4:0] gap_vec_t;
  typedef logic [31:0][5:0] cnt_vec_t;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } stage_en_t;

  // isolate lowest set bit
  function automatic logic [31:0] lowbit32(input logic [31:0] x);
    lowbit32 = x & (~x + 32'd1);
  endfunction

  // one-hot to binary index
  function automatic logic [4:0] enc32(input logic [31:0] oh);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (oh[i]) r = r | 5'(i);
    end
    enc32 = r;
  endfunction

endpackage

FILE: sv/cgpr_cfg.sv
// apb register file: the pattern_bits register
// depends on cgpr_pkg
module cgpr_cfg import cgpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [5:0]  pattern_bits
);

  logic sel_reg;
  assign sel_reg = (paddr[2] == 1'(RegPatternBits));
  assign pready  = 1'b1;
  assign prdata  = sel_reg ? {26'd0, pattern_bits} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bits <= 6'd32;
    end else if (psel && penable && pwrite && sel_reg) begin
      pattern_bits <= pwdata[5:0];
    end
  end

endmodule

FILE: sv/cgpr_front.sv
// first two stages for one pattern: zero masks, list cut, per-zero gaps
// depends on cgpr_pkg
module cgpr_front import cgpr_pkg::*; (
  input  logic        clk,
  input  stage_en_t   en,
  input  logic [31:0] pattern,
  input  logic [5:0]  n,
  output logic [31:0] inc,
  output gap_vec_t    gap
);

  logic [31:0] lm, z, o, dz, low, incm;
  logic [63:0] zd, dd;
  logic [31:0] s1_inc;
  logic [63:0] s1_d;
  gap_vec_t    gap_next;

  always_comb begin
    lm   = (n >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << n[4:0]) - 32'd1);
    z    = ~pattern & lm;
    o    = pattern & lm;
    zd   = {32'd0, z} | ({32'd0, z} << n);
    dd   = {32'd0, o} | ({32'd0, o} << n);
    // zero followed by a zero ends the scan
    dz   = z & zd[32:1];
    low  = lowbit32(dz);
    incm = low ^ (low - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (en.en1) begin
      s1_inc <= z & incm;
      s1_d   <= dd;
    end
  end

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      gap_next[i] = enc32(lowbit32(~s1_d[i+1 +: 32]));
    end
  end

  always_ff @(posedge clk) begin
    if (en.en2) begin
      inc <= s1_inc;
      gap <= gap_next;
    end
  end

endmodule

FILE: sv/cgpr_hist.sv
// third stage for one pattern: histogram of the listed gaps
// depends on cgpr_pkg
module cgpr_hist import cgpr_pkg::*; (
  input  logic        clk,
  input  stage_en_t   en,
  input  logic [31:0] inc,
  input  gap_vec_t    gap,
  output cnt_vec_t    cnt
);

  cnt_vec_t    cnt_next;
  logic [31:0] hit;

  always_comb begin
    for (int g = 0; g < 32; g++) begin
      for (int i = 0; i < 32; i++) begin
        hit[i] = inc[i] && (gap[i] == 5'(g));
      end
      cnt_next[g] = 6'($countones(hit));
    end
  end

  always_ff @(posedge clk) begin
    if (en.en3) cnt <= cnt_next;
  end

endmodule

FILE: sv/circular_gap_pattern_ranker.sv
// circular gap pattern ranker, top level
// depends on cgpr_pkg, cgpr_cfg, cgpr_front, cgpr_hist, assert_macros.svh
//
// One transaction carries two patterns; one result transaction comes back per
// input, in order. A new pair is accepted every cycle while item_ready is high:
// four register stages (masks and scan cut, per-zero gap counts, gap histogram,
// histogram compare) each hold their own valid bit and only stall when the
// stage after them is full and cannot move on, so a result waiting at the output
// does not block intake while bubbles remain.
// Comparing sorted gap lists is done on histograms: the smallest gap value
// whose counts differ decides, the pattern with fewer of that gap ranks
// better, and equal histograms fall back to the larger full 32-bit value.
// pattern_bits sits at byte address 0 of the apb port and is clamped to
// 8..32 when used; write it only while the pipeline is empty.
module circular_gap_pattern_ranker import cgpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result
);

`include "assert_macros.svh"

  logic [5:0] pattern_bits, n;
  logic       v1, v2, v3, v4;
  logic       r1, r2, r3, r4;
  stage_en_t  en;
  logic       gt1, gt2, gt3;
  logic [31:0] inc_a, inc_b;
  gap_vec_t   gap_a, gap_b;
  cnt_vec_t   cnt_a, cnt_b;
  logic [31:0] diff, less, nz_a, nz_b, dlow;
  result_t    result_next;

  cgpr_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .pattern_bits
  );

  // clamp the register to the supported width range
  always_comb begin
    if (pattern_bits < 6'(MinBits)) n = 6'(MinBits);
    else if (pattern_bits > 6'(MaxBits)) n = 6'(MaxBits);
    else n = pattern_bits;
  end

  // per-stage ready: a stage may load when empty or when it is moving on
  assign r4 = !v4 || result_ready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign item_ready = r1;
  assign en = '{en1: r1, en2: r2, en3: r3};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= item_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  cgpr_front u_front_a (.clk, .en, .pattern(item.pattern_a), .n, .inc(inc_a), .gap(gap_a));
  cgpr_front u_front_b (.clk, .en, .pattern(item.pattern_b), .n, .inc(inc_b), .gap(gap_b));
  cgpr_hist  u_hist_a  (.clk, .en, .inc(inc_a), .gap(gap_a), .cnt(cnt_a));
  cgpr_hist  u_hist_b  (.clk, .en, .inc(inc_b), .gap(gap_b), .cnt(cnt_b));

  // tie-break on the full values travels alongside
  always_ff @(posedge clk) begin
    if (r1) gt1 <= item.pattern_a > item.pattern_b;
    if (r2) gt2 <= gt1;
    if (r3) gt3 <= gt2;
  end

  // final stage: first differing gap value decides, else the tie-break; valid flags and smallest gaps
  always_comb begin
    for (int g = 0; g < 32; g++) begin
      diff[g] = cnt_a[g] != cnt_b[g];
      less[g] = cnt_a[g] < cnt_b[g];
      nz_a[g] = cnt_a[g] != 6'd0;
      nz_b[g] = cnt_b[g] != 6'd0;
    end
    dlow = lowbit32(diff);
    result_next.a_better  = (|diff) ? |(dlow & less) : gt3;
    result_next.a_valid   = (|nz_a) && !nz_a[0];
    result_next.b_valid   = (|nz_b) && !nz_b[0];
    result_next.a_min_gap = enc32(lowbit32(nz_a));
    result_next.b_min_gap = enc32(lowbit32(nz_b));
  end

  always_ff @(posedge clk) begin
    if (r4) result <= result_next;
  end

  assign result_valid = v4;

  `CGPR_ASSERT(a_valid_has_gap, (result_valid && result.a_valid) |-> (result.a_min_gap != 5'd0))
  `CGPR_ASSERT(b_valid_has_gap, (result_valid && result.b_valid) |-> (result.b_min_gap != 5'd0))
  `CGPR_ASSERT_NEXT(stalled_result_kept, result_valid && !result_ready, result_valid)

endmodule

FILE: tb/sv/circular_gap_pattern_ranker_test.sv
// testbench for the circular gap pattern ranker: directed and random pattern pairs,
// apb writes of pattern_bits, result checking against an in-bench predictor
// depends on cgpr_pkg and circular_gap_pattern_ranker
module circular_gap_pattern_ranker_test;
  import cgpr_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        item_valid;
  logic        item_ready;
  item_t       item;
  logic        result_valid;
  logic        result_ready;
  result_t     result;

  // predictor copy of the register and queue of predicted results
  logic [5:0]  bits_reg;
  result_t     pending_results[$];
  int          mismatches;
  int          checked;
  int          sent;
  bit          hold_off;   // long receiver stall requested by a test
  bit          rx_calm;    // receiver never stalls while set

  circular_gap_pattern_ranker uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // gap list of one pattern, kept as a histogram plus count and smallest gap
  function automatic void gap_hist(input logic [31:0] p, input int n, output int hist[32],
                                   output int cnt, output int min_gap);
    int g;
    int loc;
    bit stop;
    for (int i = 0; i < 32; i++) hist[i] = 0;
    cnt = 0;
    min_gap = 99;
    stop = 0;
    for (int pos = 0; pos < n && !stop; pos++) begin
      if (!p[pos]) begin
        g = 0;
        for (int k = 1; k < n; k++) begin
          loc = (pos + k) % n;
          if (!p[loc]) break;
          g++;
        end
        hist[g]++;
        cnt++;
        if (g < min_gap) min_gap = g;
        // scan stops after the first zero gap
        if (g == 0) stop = 1;
      end
    end
  endfunction

  function automatic result_t rank_pair(input item_t it, input logic [5:0] reg_bits);
    int n;
    int ha[32];
    int hb[32];
    int ca, cb, ma, mb;
    int ra, rb;
    result_t r;
    n = reg_bits;
    if (n < MinBits) n = MinBits;
    if (n > MaxBits) n = MaxBits;
    gap_hist(it.pattern_a, n, ha, ca, ma);
    gap_hist(it.pattern_b, n, hb, cb, mb);
    r.a_better = 1'b0;
    // walk both sorted lists in step, smallest gap first
    ra = 0;
    rb = 0;
    begin : walk
      int ga, gb;
      ga = 0;
      gb = 0;
      forever begin
        while (ga < 32 && ra >= ha[ga]) begin ga++; ra = 0; end
        while (gb < 32 && rb >= hb[gb]) begin gb++; rb = 0; end
        if (ga >= 32) begin
          r.a_better = (gb >= 32) ? (it.pattern_a > it.pattern_b) : 1'b1;
          break;
        end
        if (gb >= 32) begin
          r.a_better = 1'b0;
          break;
        end
        if (ga != gb) begin
          r.a_better = ga > gb;
          break;
        end
        ra++;
        rb++;
      end
    end
    r.a_valid   = (ca > 0) && (ma > 0);
    r.b_valid   = (cb > 0) && (mb > 0);
    r.a_min_gap = (ca > 0) ? 5'(ma) : 5'd0;
    r.b_min_gap = (cb > 0) ? 5'(mb) : 5'd0;
    return r;
  endfunction

  // one apb write, with the pipeline already drained
  task automatic write_pattern_bits(input logic [5:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(RegPatternBits * 4);
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    bits_reg = v;
  endtask

  // send one pair; the prediction is queued when the transaction is accepted
  task automatic send_pair(input logic [31:0] pa, input logic [31:0] pb);
    item_t it;
    it.pattern_a = pa;
    it.pattern_b = pb;
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    pending_results.push_back(rank_pair(it, bits_reg));
    sent++;
  endtask

  task automatic idle_sender();
    item_valid <= 1'b0;
  endtask

  // sender bursts with gaps between them
  task automatic send_random_burst(input int count, input int style);
    logic [31:0] pa, pb;
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      pa = rand_pattern(style);
      pb = rand_pattern(style);
      if ($urandom_range(0, 15) == 0) pb = pa;
      send_pair(pa, pb);
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 2) == 0) begin
          idle_sender();
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end else begin
        burst--;
      end
    end
    idle_sender();
  endtask

  // mostly valid-looking codes: isolated zeros with random spacing
  function automatic logic [31:0] rand_pattern(input int style);
    logic [31:0] p;
    int pos;
    case ($urandom_range(0, 5) + style)
      0, 1: p = $urandom();
      2: p = ~($urandom() & $urandom() & $urandom());
      default: begin
        p = '1;
        pos = $urandom_range(0, 3);
        while (pos < 32) begin
          p[pos] = 1'b0;
          pos += $urandom_range(2, 9);
        end
        if ($urandom_range(0, 9) == 0) p = '1;
        if ($urandom_range(0, 9) == 0) p[$urandom_range(0, 31)] = 1'b0;
      end
    endcase
    return p;
  endfunction

  // wait until all predicted results have arrived, then idle before returning
  task automatic drain();
    int guard;
    guard = 0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic test_directed();
    write_pattern_bits(6'd32);
    send_pair(32'h0000_0000, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'h0000_0000);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFE, 32'h7FFF_FFFF);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555);
    send_pair(32'h5555_5555, 32'h5555_5555);
    send_pair(32'hEEEE_EEEE, 32'hDB6D_B6DB);
    send_pair(32'hFFFE_FFFE, 32'hFFFF_FFFC);
    send_pair(32'h7FFF_FFFE, 32'hFFFF_FFFE);
    send_pair(32'h1234_5678, 32'h1234_5678);
    idle_sender();
    drain();
    // narrow code: high bits only break ties
    write_pattern_bits(6'd8);
    send_pair(32'hFFFF_FFEE, 32'h0000_00EE);
    send_pair(32'h0000_00EE, 32'hFFFF_FFEE);
    send_pair(32'h0000_00FF, 32'h0000_007F);
    send_pair(32'hA5A5_A5FE, 32'h5A5A_5AFD);
    idle_sender();
    drain();
    // register below and above range clamps
    write_pattern_bits(6'd0);
    send_pair(32'h0000_00EE, 32'h0000_01EE);
    send_pair(32'hFFFF_FF7F, 32'h0000_0000);
    idle_sender();
    drain();
    write_pattern_bits(6'd63);
    send_pair(32'hFFFF_FFFE, 32'hFFFE_FFFF);
    send_pair(32'h8000_0000, 32'h0000_0001);
    idle_sender();
    drain();
  endtask

  task automatic test_random_settings();
    logic [5:0] settings[6] = '{6'd32, 6'd8, 6'd17, 6'd31, 6'd9, 6'd24};
    foreach (settings[i]) begin
      write_pattern_bits(settings[i]);
      send_random_burst(260, 0);
      drain();
    end
    write_pattern_bits(6'($urandom_range(0, 63)));
    send_random_burst(120, 2);
    drain();
  endtask

  // long receiver hold-off while the sender keeps offering pairs
  task automatic test_backpressure();
    write_pattern_bits(6'd32);
    hold_off = 1'b1;
    fork
      send_random_burst(60, 0);
      begin
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    drain();
    rx_calm = 1'b1;
    send_random_burst(80, 3);
    drain();
    rx_calm = 1'b0;
  endtask

  // receiver stall pattern, independent of the sender
  initial begin
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) result_ready <= 1'b0;
      else if (rx_calm) result_ready <= 1'b1;
      else result_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", result);
      end else begin
        result_t want;
        want = pending_results.pop_front();
        checked++;
        if (want.a_better !== result.a_better || want.a_valid !== result.a_valid ||
            want.b_valid !== result.b_valid || want.a_min_gap !== result.a_min_gap ||
            want.b_min_gap !== result.b_min_gap) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, result);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_valid = 1'b0;
    item = '0;
    bits_reg = 6'd32;
    mismatches = 0;
    checked = 0;
    sent = 0;
    hold_off = 1'b0;
    rx_calm = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_settings();
    test_backpressure();
    drain();
    mismatches += pending_results.size();
    $display("covered %0d pattern pairs over several code widths, %0d results checked",
             sent, checked);
    $display("including clamped register values and a long output stall");
    if (mismatches == 0) begin
      $display("[circular_gap_pattern_ranker] OK");
    end else begin
      $display("[circular_gap_pattern_ranker] ERROR");
    end
    $finish;
  end

  // timeout guard
  initial begin
    #5000000;
    $display("[circular_gap_pattern_ranker] ERROR");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/cgpr_pkg.sv
sv/cgpr_cfg.sv
sv/cgpr_front.sv
sv/cgpr_hist.sv
sv/circular_gap_pattern_ranker.sv
tb/sv/circular_gap_pattern_ranker_test.sv
